// ===== design/omefc_pkg.sv =====
// ----------------------------------------------------------------------------
// omefc_pkg
// Shared widths, coefficients, command types and the micro-program of the
// outer and middle ear filter cascade.
// ----------------------------------------------------------------------------
package omefc_pkg;

    localparam int STATE_W    = 48;
    localparam int COEF_W     = 32;
    localparam int IN_W       = 32;
    localparam int OUT_W      = 48;
    localparam int ACC_W      = 84;
    localparam int PART_W     = STATE_W / 2;
    localparam int PROD_W     = PART_W + 1 + COEF_W;
    localparam int FRAC_SHIFT = 30;
    localparam int ATT_SHIFT  = 50;
    localparam int IN_SHIFT   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int N_STEPS    = 28;
    localparam int STEP_W     = $clog2(N_STEPS);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(N_STEPS - 1);

    localparam logic signed [COEF_W-1:0] GAIN_RST = 32'sd1909412977;
    localparam logic signed [COEF_W-1:0] HP_B0    = 32'sd1040862072;
    localparam logic signed [COEF_W-1:0] HP_B1    = -32'sd2081724144;
    localparam logic signed [COEF_W-1:0] HP_A1    = -32'sd2080717075;
    localparam logic signed [COEF_W-1:0] HP_A2    = 32'sd1008989389;
    localparam logic signed [COEF_W-1:0] LP_A1    = -32'sd1073067172;
    localparam logic signed [COEF_W-1:0] LP_B     = 32'sd674652;
    localparam logic signed [COEF_W-1:0] ATT_Q50  = 32'sd562949953;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONCHA_B0   = 3'd0,
        CFG_CONCHA_A1   = 3'd1,
        CFG_CONCHA_A2   = 3'd2,
        CFG_CONCHA_GAIN = 3'd3,
        CFG_CANAL_B0    = 3'd4,
        CFG_CANAL_A1    = 3'd5,
        CFG_CANAL_A2    = 3'd6,
        CFG_CANAL_GAIN  = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_MAC,
        OP_LOAD,
        OP_FIN
    } t_op;

    typedef enum logic [4:0] {
        SRC_X, SRC_C, SRC_E, SRC_R, SRC_EO, SRC_AR, SRC_V, SRC_D,
        SRC_CIN1, SRC_COUT0, SRC_COUT1,
        SRC_NIN1, SRC_NOUT0, SRC_NOUT1,
        SRC_SIN0, SRC_SIN1, SRC_SOUT0, SRC_SOUT1
    } t_src;

    typedef enum logic [3:0] {
        CF_CB0, CF_CA1, CF_CA2, CF_CGAIN,
        CF_NB0, CF_NA1, CF_NA2, CF_NGAIN,
        CF_HPB0, CF_HPB1, CF_HPA1, CF_HPA2,
        CF_LPB, CF_LPA1, CF_ATT
    } t_coef;

    typedef enum logic [2:0] {
        DST_C, DST_E, DST_R, DST_EO, DST_AR, DST_V, DST_D
    } t_dst;

    typedef struct packed {
        t_op   op;
        t_src  src;
        t_coef coef;
        logic  neg;
        logic  sh50;
        t_dst  dst;
    } t_uop;

    typedef struct packed {
        t_uop uop;
        logic hi;
        logic push;
        logic take_in;
    } t_cmd;

    function automatic t_uop mk(input t_op op, input t_src src, input t_coef coef,
                                input logic neg, input logic sh50, input t_dst dst);
        t_uop u;
        u.op   = op;
        u.src  = src;
        u.coef = coef;
        u.neg  = neg;
        u.sh50 = sh50;
        u.dst  = dst;
        return u;
    endfunction

    // A result written by a finish step is never read by the step right after
    // it, since the write goes through the multiplier-stage registers first.
    function automatic t_uop prog(input logic [STEP_W-1:0] step);
        t_uop u;
        u = mk(OP_NOP, SRC_X, CF_CB0, 1'b0, 1'b0, DST_C);
        case (step)
            5'd0:  u = mk(OP_MAC,  SRC_X,     CF_CB0,   1'b0, 1'b0, DST_C);
            5'd1:  u = mk(OP_MAC,  SRC_CIN1,  CF_CB0,   1'b1, 1'b0, DST_C);
            5'd2:  u = mk(OP_MAC,  SRC_COUT0, CF_CA1,   1'b1, 1'b0, DST_C);
            5'd3:  u = mk(OP_MAC,  SRC_COUT1, CF_CA2,   1'b1, 1'b0, DST_C);
            5'd4:  u = mk(OP_FIN,  SRC_X,     CF_CB0,   1'b0, 1'b0, DST_C);
            5'd5:  u = mk(OP_LOAD, SRC_X,     CF_CB0,   1'b0, 1'b0, DST_C);
            5'd6:  u = mk(OP_MAC,  SRC_C,     CF_CGAIN, 1'b0, 1'b0, DST_C);
            5'd7:  u = mk(OP_FIN,  SRC_X,     CF_CB0,   1'b0, 1'b0, DST_E);
            5'd8:  u = mk(OP_MAC,  SRC_NIN1,  CF_NB0,   1'b1, 1'b0, DST_E);
            5'd9:  u = mk(OP_MAC,  SRC_NOUT0, CF_NA1,   1'b1, 1'b0, DST_E);
            5'd10: u = mk(OP_MAC,  SRC_NOUT1, CF_NA2,   1'b1, 1'b0, DST_E);
            5'd11: u = mk(OP_MAC,  SRC_E,     CF_NB0,   1'b0, 1'b0, DST_E);
            5'd12: u = mk(OP_FIN,  SRC_X,     CF_CB0,   1'b0, 1'b0, DST_R);
            5'd13: u = mk(OP_LOAD, SRC_E,     CF_CB0,   1'b0, 1'b0, DST_R);
            5'd14: u = mk(OP_MAC,  SRC_R,     CF_NGAIN, 1'b0, 1'b0, DST_R);
            5'd15: u = mk(OP_FIN,  SRC_X,     CF_CB0,   1'b0, 1'b0, DST_EO);
            5'd16: u = mk(OP_NOP,  SRC_X,     CF_CB0,   1'b0, 1'b0, DST_EO);
            5'd17: u = mk(OP_MAC,  SRC_EO,    CF_ATT,   1'b0, 1'b0, DST_AR);
            5'd18: u = mk(OP_FIN,  SRC_X,     CF_CB0,   1'b0, 1'b1, DST_AR);
            5'd19: u = mk(OP_MAC,  SRC_SIN0,  CF_HPB1,  1'b0, 1'b0, DST_V);
            5'd20: u = mk(OP_MAC,  SRC_SIN1,  CF_HPB0,  1'b0, 1'b0, DST_V);
            5'd21: u = mk(OP_MAC,  SRC_SOUT0, CF_HPA1,  1'b1, 1'b0, DST_V);
            5'd22: u = mk(OP_MAC,  SRC_SOUT1, CF_HPA2,  1'b1, 1'b0, DST_V);
            5'd23: u = mk(OP_MAC,  SRC_AR,    CF_HPB0,  1'b0, 1'b0, DST_V);
            5'd24: u = mk(OP_FIN,  SRC_X,     CF_CB0,   1'b0, 1'b0, DST_V);
            5'd25: u = mk(OP_MAC,  SRC_D,     CF_LPA1,  1'b1, 1'b0, DST_D);
            5'd26: u = mk(OP_MAC,  SRC_V,     CF_LPB,   1'b0, 1'b0, DST_D);
            5'd27: u = mk(OP_FIN,  SRC_X,     CF_CB0,   1'b0, 1'b0, DST_D);
            default: u = mk(OP_NOP, SRC_X,    CF_CB0,   1'b0, 1'b0, DST_C);
        endcase
        return u;
    endfunction

endpackage

// ===== design/omefc_in_if.sv =====
// ----------------------------------------------------------------------------
// omefc_in_if
// Sample input channel: valid/ready handshake with one pressure sample.
// ----------------------------------------------------------------------------
interface omefc_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [omefc_pkg::IN_W-1:0]       pressure_sample;

    modport source (output valid, output pressure_sample, input ready);
    modport sink   (input valid, input pressure_sample, output ready);
endinterface

// ===== design/omefc_out_if.sv =====
// ----------------------------------------------------------------------------
// omefc_out_if
// Result channel: valid/ready handshake with one stapes displacement sample.
// ----------------------------------------------------------------------------
interface omefc_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [omefc_pkg::OUT_W-1:0]      stapes_displacement;

    modport source (output valid, output stapes_displacement, input ready);
    modport sink   (input valid, input stapes_displacement, output ready);
endinterface

// ===== design/omefc_ctrl.sv =====
// ----------------------------------------------------------------------------
// omefc_ctrl
// Sequencer: walks the micro-program once per sample and tracks the result
// register's handshake.
// ----------------------------------------------------------------------------
module omefc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output omefc_pkg::t_cmd   o_cmd
);
    import omefc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_half, n_half;
    logic                r_out_valid, n_out_valid;
    logic                r_fin_pend, n_fin_pend;

    t_uop                uop;
    logic                is_last;
    logic                stall;
    logic                issue;

    always_comb begin
        uop     = prog(r_step);
        is_last = (r_step == LAST_STEP);
        // The last finish overwrites the result register, so it waits until
        // the previous result is gone or leaves in this cycle.
        stall   = is_last && r_out_valid && !i_out_ready;
        issue   = (r_state == S_RUN) && !stall;

        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = r_out_valid;

        o_cmd         = '0;
        o_cmd.uop     = uop;
        o_cmd.uop.op  = issue ? uop.op : OP_NOP;
        o_cmd.hi      = r_half;
        o_cmd.push    = is_last;
        o_cmd.take_in = i_in_valid && o_in_ready;
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_half  = r_half;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RUN;
                    n_step  = '0;
                    n_half  = 1'b0;
                end
            end
            S_RUN: begin
                if (issue) begin
                    if (uop.op == OP_MAC && !r_half) begin
                        n_half = 1'b1;
                    end else begin
                        n_half = 1'b0;
                        if (is_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_step = r_step + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_fin_pend  = issue && is_last;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (r_fin_pend) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
            r_fin_pend  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_half      <= n_half;
            r_out_valid <= n_out_valid;
            r_fin_pend  <= n_fin_pend;
        end
    end

    a_fin_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.uop.op == OP_FIN && o_cmd.push) |-> (!r_out_valid || i_out_ready))
        else $error("final finish issued while the result register is held");

    // The final finish is issued and registered in r_fin_pend, which then sets result valid.
    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(issue && is_last, 2))
        else $error("result valid rose without a final finish");

    a_fin_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_pend |=> r_out_valid)
        else $error("result valid missing after final finish");

    a_half_on_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (r_state == S_RUN && prog(r_step).op == OP_MAC))
        else $error("upper half outside a multiply step");

endmodule

// ===== design/omefc_dp.sv =====
// ----------------------------------------------------------------------------
// omefc_dp
// Datapath: coefficient and history registers, one shared 25x32 multiplier,
// an exact accumulator and the round/shift/saturate finish.
// ----------------------------------------------------------------------------
module omefc_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  omefc_pkg::t_cmd                        i_cmd,
    input  logic signed [omefc_pkg::IN_W-1:0]      i_pressure_sample,
    input  logic                                   i_cfg_wr_en,
    input  logic [omefc_pkg::CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [omefc_pkg::COEF_W-1:0]           i_cfg_wdata,
    output logic signed [omefc_pkg::OUT_W-1:0]     o_stapes_displacement
);
    import omefc_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [ACC_W-1:0] HALF30  = ACC_W'(1) <<< (FRAC_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] HALF50  = ACC_W'(1) <<< (ATT_SHIFT - 1);

    // Writable coefficients.
    logic signed [COEF_W-1:0]  r_cb0, r_ca1, r_ca2, r_cgain;
    logic signed [COEF_W-1:0]  r_nb0, r_na1, r_na2, r_ngain;

    // Per-sample intermediates.
    logic signed [STATE_W-1:0] r_x, r_c, r_e, r_r, r_eo, r_ar, r_v;
    logic signed [STATE_W-1:0] r_d;

    // Histories: index 0 is one sample back, index 1 two back.
    logic signed [STATE_W-1:0] r_cin_h  [2];
    logic signed [STATE_W-1:0] r_cout_h [2];
    logic signed [STATE_W-1:0] r_nin_h  [2];
    logic signed [STATE_W-1:0] r_nout_h [2];
    logic signed [STATE_W-1:0] r_sin_h  [2];
    logic signed [STATE_W-1:0] r_sout_h [2];

    // Multiplier stage.
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [STATE_W-1:0] r_opnd;
    t_op                       r_p_op;
    logic                      r_p_hi, r_p_neg, r_p_sh50, r_p_push;
    t_dst                      r_p_dst;

    logic signed [ACC_W-1:0]   r_acc, n_acc;

    logic signed [STATE_W-1:0] opnd;
    logic signed [COEF_W-1:0]  coef;
    logic signed [PART_W:0]    part;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   term, term_sh, addend, load_val, rnd, shifted;
    logic signed [STATE_W-1:0] fin_val;

    // Stage 1: operand and coefficient selection, one partial product.
    always_comb begin
        case (i_cmd.uop.src)
            SRC_X:     opnd = r_x;
            SRC_C:     opnd = r_c;
            SRC_E:     opnd = r_e;
            SRC_R:     opnd = r_r;
            SRC_EO:    opnd = r_eo;
            SRC_AR:    opnd = r_ar;
            SRC_V:     opnd = r_v;
            SRC_D:     opnd = r_d;
            SRC_CIN1:  opnd = r_cin_h[1];
            SRC_COUT0: opnd = r_cout_h[0];
            SRC_COUT1: opnd = r_cout_h[1];
            SRC_NIN1:  opnd = r_nin_h[1];
            SRC_NOUT0: opnd = r_nout_h[0];
            SRC_NOUT1: opnd = r_nout_h[1];
            SRC_SIN0:  opnd = r_sin_h[0];
            SRC_SIN1:  opnd = r_sin_h[1];
            SRC_SOUT0: opnd = r_sout_h[0];
            SRC_SOUT1: opnd = r_sout_h[1];
            default:   opnd = r_x;
        endcase

        case (i_cmd.uop.coef)
            CF_CB0:   coef = r_cb0;
            CF_CA1:   coef = r_ca1;
            CF_CA2:   coef = r_ca2;
            CF_CGAIN: coef = r_cgain;
            CF_NB0:   coef = r_nb0;
            CF_NA1:   coef = r_na1;
            CF_NA2:   coef = r_na2;
            CF_NGAIN: coef = r_ngain;
            CF_HPB0:  coef = HP_B0;
            CF_HPB1:  coef = HP_B1;
            CF_HPA1:  coef = HP_A1;
            CF_HPA2:  coef = HP_A2;
            CF_LPB:   coef = LP_B;
            CF_LPA1:  coef = LP_A1;
            CF_ATT:   coef = ATT_Q50;
            default:  coef = r_cb0;
        endcase

        // The upper half is signed, the lower half is an unsigned magnitude.
        if (i_cmd.hi) begin
            part = {opnd[STATE_W-1], opnd[STATE_W-1:PART_W]};
        end else begin
            part = {1'b0, opnd[PART_W-1:0]};
        end
        prod = PROD_W'(part) * PROD_W'(coef);
    end

    // Stage 2: accumulate, load or finish.
    always_comb begin
        term     = ACC_W'(r_prod);
        term_sh  = r_p_hi ? (term <<< PART_W) : term;
        addend   = r_p_neg ? -term_sh : term_sh;
        load_val = ACC_W'(r_opnd) <<< FRAC_SHIFT;
        rnd      = r_acc + (r_p_sh50 ? HALF50 : HALF30);
        shifted  = r_p_sh50 ? (rnd >>> ATT_SHIFT) : (rnd >>> FRAC_SHIFT);

        if (shifted > SAT_MAX) begin
            fin_val = SAT_MAX[STATE_W-1:0];
        end else if (shifted < SAT_MIN) begin
            fin_val = SAT_MIN[STATE_W-1:0];
        end else begin
            fin_val = shifted[STATE_W-1:0];
        end

        case (r_p_op)
            OP_MAC:  n_acc = r_acc + addend;
            OP_LOAD: n_acc = load_val;
            OP_FIN:  n_acc = '0;
            default: n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= prod;
        r_opnd   <= opnd;
        r_p_hi   <= i_cmd.hi;
        r_p_neg  <= i_cmd.uop.neg;
        r_p_sh50 <= i_cmd.uop.sh50;
        r_p_dst  <= i_cmd.uop.dst;
        r_p_push <= i_cmd.push;

        if (i_cmd.take_in) begin
            r_x <= STATE_W'(i_pressure_sample) <<< IN_SHIFT;
        end

        if (r_p_op == OP_FIN) begin
            case (r_p_dst)
                DST_C:   r_c  <= fin_val;
                DST_E:   r_e  <= fin_val;
                DST_R:   r_r  <= fin_val;
                DST_EO:  r_eo <= fin_val;
                DST_AR:  r_ar <= fin_val;
                DST_V:   r_v  <= fin_val;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_op     <= OP_NOP;
            r_acc      <= '0;
            r_d        <= '0;
            r_cb0      <= '0;
            r_ca1      <= '0;
            r_ca2      <= '0;
            r_cgain    <= GAIN_RST;
            r_nb0      <= '0;
            r_na1      <= '0;
            r_na2      <= '0;
            r_ngain    <= GAIN_RST;
            r_cin_h    <= '{default: '0};
            r_cout_h   <= '{default: '0};
            r_nin_h    <= '{default: '0};
            r_nout_h   <= '{default: '0};
            r_sin_h    <= '{default: '0};
            r_sout_h   <= '{default: '0};
        end else begin
            r_p_op <= i_cmd.uop.op;
            r_acc  <= n_acc;

            // The final finish writes the displacement and shifts every
            // history with this sample's stage values.
            if (r_p_op == OP_FIN && r_p_dst == DST_D) begin
                r_d <= fin_val;
            end
            if (r_p_op == OP_FIN && r_p_push) begin
                r_cin_h  <= '{r_x,  r_cin_h[0]};
                r_cout_h <= '{r_c,  r_cout_h[0]};
                r_nin_h  <= '{r_e,  r_nin_h[0]};
                r_nout_h <= '{r_r,  r_nout_h[0]};
                r_sin_h  <= '{r_ar, r_sin_h[0]};
                r_sout_h <= '{r_v,  r_sout_h[0]};
            end

            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_CONCHA_B0:   r_cb0   <= i_cfg_wdata;
                    CFG_CONCHA_A1:   r_ca1   <= i_cfg_wdata;
                    CFG_CONCHA_A2:   r_ca2   <= i_cfg_wdata;
                    CFG_CONCHA_GAIN: r_cgain <= i_cfg_wdata;
                    CFG_CANAL_B0:    r_nb0   <= i_cfg_wdata;
                    CFG_CANAL_A1:    r_na1   <= i_cfg_wdata;
                    CFG_CANAL_A2:    r_na2   <= i_cfg_wdata;
                    CFG_CANAL_GAIN:  r_ngain <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    assign o_stapes_displacement = r_d;

endmodule

// ===== design/outer_middle_ear_filter_cascade.sv =====
// ----------------------------------------------------------------------------
// outer_middle_ear_filter_cascade
// Concha and ear canal resonances, attenuation, stapes high-pass and a
// first-order low-pass from sound pressure to stapes displacement.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake        Payload
//  i_smp     in    valid / ready    pressure_sample      32 bit signed
//  o_disp    out   valid / ready    stapes_displacement  48 bit signed
//  i_cfg_*   in    write enable     addr 3 bit, data 32 bit
//
// Each sample is accepted in the idle state and then runs the 28 program
// steps, 18 of them multiplies done in two halves each on the single 25x32
// multiplier; no new sample is accepted until the steps are done.
// Reset clears all filter histories and loads the default coefficients.
// The result register holds a sample until it is taken; the next sample is
// accepted meanwhile and only its final step waits for the register to free.
// ----------------------------------------------------------------------------
module outer_middle_ear_filter_cascade (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    omefc_in_if.sink                            i_smp,
    omefc_out_if.source                         o_disp,
    input  logic                                i_cfg_wr_en,
    input  logic [omefc_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [omefc_pkg::COEF_W-1:0]        i_cfg_wdata
);
    import omefc_pkg::*;

    t_cmd cmd;

    omefc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_smp.valid),
        .o_in_ready  (i_smp.ready),
        .o_out_valid (o_disp.valid),
        .i_out_ready (o_disp.ready),
        .o_cmd       (cmd)
    );

    omefc_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .i_pressure_sample     (i_smp.pressure_sample),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_addr            (i_cfg_addr),
        .i_cfg_wdata           (i_cfg_wdata),
        .o_stapes_displacement (o_disp.stapes_displacement)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the outer and middle ear filter cascade. A directed
// table covers reset behavior, sample extremes and saturating coefficients.
// Random phases follow, each with freshly written coefficients: stable
// resonators, arbitrary values, extremes, and finally the reset values. Each
// result is checked against a bit-exact fixed-point predictor or a typed value.
// ----------------------------------------------------------------------------
module testbench;
    import omefc_pkg::*;

    localparam int SW              = 48;
    localparam int Q_FRAC          = 30;
    localparam int ATT_FRAC        = 50;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int N_PHASES        = 10;
    localparam int ITEMS_PER_PHASE = 123;
    localparam int SETTLE_CYCLES   = 100;
    localparam int N_DIR           = 21;

    typedef logic signed [127:0]       t_wide;
    typedef logic signed [SW-1:0]      t_sample;
    typedef logic signed [COEF_W-1:0]  t_coef_val;

    localparam t_wide SAT_HI = 128'sd140737488355327;
    localparam t_wide SAT_LO = -128'sd140737488355328;

    localparam t_coef_val UNITY    = 32'sd1073741824;
    localparam t_coef_val DEF_GAIN = 32'sd1909412977;
    localparam t_coef_val HPF_B0   = 32'sd1040862072;
    localparam t_coef_val HPF_B1   = -32'sd2081724144;
    localparam t_coef_val HPF_A1   = -32'sd2080717075;
    localparam t_coef_val HPF_A2   = 32'sd1008989389;
    localparam t_coef_val LPF_A1   = -32'sd1073067172;
    localparam t_coef_val LPF_B    = 32'sd674652;
    localparam t_coef_val ATTEN    = 32'sd562949953;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {MODE_STABLE, MODE_WILD, MODE_EXTREME, MODE_DEFAULT} t_coef_mode;

    typedef struct packed {
        t_row_kind   kind;
        t_cfg_idx    reg_idx;
        logic [31:0] value;
        logic        typed;
        t_sample     typed_val;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [COEF_W-1:0]     cfg_wdata;

    omefc_in_if  smp_ch ();
    omefc_out_if disp_ch ();

    outer_middle_ear_filter_cascade uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smp       (smp_ch),
        .o_disp      (disp_ch),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: coefficients and filter histories (index 0 is newest).
    t_coef_val cfg_model [8];
    t_sample   concha_x [2], concha_y [2];
    t_sample   canal_x [2], canal_y [2];
    t_sample   hp_x [2], hp_y [2];
    t_sample   lp_y;

    t_sample     displacement_q [$];
    t_sample     want_disp;
    int          mismatches = 0;
    int unsigned cycle_count = 0;
    logic        calm = 1'b0;
    logic        in_held = 1'b0;

    t_dir_row dir_rows [N_DIR] = '{
        '{ROW_SAMPLE, CFG_CONCHA_B0,   32'h0000_0000, 1'b1, 48'sd0},
        '{ROW_SAMPLE, CFG_CONCHA_B0,   32'h0000_0000, 1'b1, 48'sd0},
        '{ROW_SAMPLE, CFG_CONCHA_B0,   32'h7FFF_FFFF, 1'b0, 48'sd0},
        '{ROW_SAMPLE, CFG_CONCHA_B0,   32'h8000_0000, 1'b0, 48'sd0},
        '{ROW_SAMPLE, CFG_CONCHA_B0,   32'h0000_0001, 1'b0, 48'sd0},
        '{ROW_SAMPLE, CFG_CONCHA_B0,   32'hFFFF_FFFF, 1'b0, 48'sd0},
        '{ROW_SAMPLE, CFG_CONCHA_B0,   32'h0000_0000, 1'b0, 48'sd0},
        '{ROW_CFG,    CFG_CONCHA_B0,   32'h7FFF_FFFF, 1'b0, 48'sd0},
        '{ROW_CFG,    CFG_CONCHA_A1,   32'h8000_0000, 1'b0, 48'sd0},
        '{ROW_CFG,    CFG_CONCHA_A2,   32'h7FFF_FFFF, 1'b0, 48'sd0},
        '{ROW_CFG,    CFG_CONCHA_GAIN, 32'h7FFF_FFFF, 1'b0, 48'sd0},
        '{ROW_CFG,    CFG_CANAL_B0,    32'h8000_0000, 1'b0, 48'sd0},
        '{ROW_CFG,    CFG_CANAL_A1,    32'h7FFF_FFFF, 1'b0, 48'sd0},
        '{ROW_CFG,    CFG_CANAL_A2,    32'h8000_0000, 1'b0, 48'sd0},
        '{ROW_CFG,    CFG_CANAL_GAIN,  32'h8000_0000, 1'b0, 48'sd0},
        '{ROW_SAMPLE, CFG_CONCHA_B0,   32'h7FFF_FFFF, 1'b0, 48'sd0},
        '{ROW_SAMPLE, CFG_CONCHA_B0,   32'h7FFF_FFFF, 1'b0, 48'sd0},
        '{ROW_SAMPLE, CFG_CONCHA_B0,   32'h8000_0000, 1'b0, 48'sd0},
        '{ROW_SAMPLE, CFG_CONCHA_B0,   32'h8000_0000, 1'b0, 48'sd0},
        '{ROW_SAMPLE, CFG_CONCHA_B0,   32'h0000_0000, 1'b0, 48'sd0},
        '{ROW_SAMPLE, CFG_CONCHA_B0,   32'h0000_0001, 1'b0, 48'sd0}
    };

    function automatic t_wide prod(input t_sample s, input t_coef_val c);
        t_wide ws, wc;
        ws = s;
        wc = c;
        return ws * wc;
    endfunction

    // Round half up, drop sh fraction bits, then clamp to the sample range.
    function automatic t_sample round_sat(input t_wide acc, input int sh);
        t_wide half, q;
        half = 1;
        half = half <<< (sh - 1);
        q = (acc + half) >>> sh;
        if (q > SAT_HI) q = SAT_HI;
        else if (q < SAT_LO) q = SAT_LO;
        return q[SW-1:0];
    endfunction

    function automatic t_sample predict_displacement(input logic signed [31:0] p);
        t_sample scaled, x, c, e, r, eo, ar, v, d;
        scaled = {p, 16'h0000};
        x = round_sat(prod(scaled, UNITY), Q_FRAC);

        c = round_sat(prod(x, cfg_model[CFG_CONCHA_B0])
                      - prod(concha_x[1], cfg_model[CFG_CONCHA_B0])
                      - prod(concha_y[0], cfg_model[CFG_CONCHA_A1])
                      - prod(concha_y[1], cfg_model[CFG_CONCHA_A2]), Q_FRAC);
        concha_x[1] = concha_x[0];  concha_x[0] = x;
        concha_y[1] = concha_y[0];  concha_y[0] = c;
        e = round_sat(prod(c, cfg_model[CFG_CONCHA_GAIN]) + prod(x, UNITY), Q_FRAC);

        r = round_sat(prod(e, cfg_model[CFG_CANAL_B0])
                      - prod(canal_x[1], cfg_model[CFG_CANAL_B0])
                      - prod(canal_y[0], cfg_model[CFG_CANAL_A1])
                      - prod(canal_y[1], cfg_model[CFG_CANAL_A2]), Q_FRAC);
        canal_x[1] = canal_x[0];  canal_x[0] = e;
        canal_y[1] = canal_y[0];  canal_y[0] = r;
        eo = round_sat(prod(r, cfg_model[CFG_CANAL_GAIN]) + prod(e, UNITY), Q_FRAC);

        ar = round_sat(prod(eo, ATTEN), ATT_FRAC);

        v = round_sat(prod(ar, HPF_B0) + prod(hp_x[0], HPF_B1) + prod(hp_x[1], HPF_B0)
                      - prod(hp_y[0], HPF_A1) - prod(hp_y[1], HPF_A2), Q_FRAC);
        hp_x[1] = hp_x[0];  hp_x[0] = ar;
        hp_y[1] = hp_y[0];  hp_y[0] = v;

        d = round_sat(prod(v, LPF_B) - prod(lp_y, LPF_A1), Q_FRAC);
        lp_y = d;
        return d;
    endfunction

    function automatic t_coef_val extreme_coef();
        case ($urandom_range(0, 4))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return 32'shFFFF_FFFF;
            default: return 32'sh4000_0000;
        endcase
    endfunction

    // Stable mode keeps both poles inside the unit circle: 0 <= a2 < 1 and
    // |a1| < 1 + a2.
    function automatic void draw_stage(input t_coef_mode mode,
                                       output t_coef_val b0, output t_coef_val a1,
                                       output t_coef_val a2, output t_coef_val gain);
        int unsigned pole;
        case (mode)
            MODE_STABLE: begin
                b0   = int'($urandom_range(0, 1 << 29)) - (1 << 28);
                pole = $urandom_range(0, (1 << 30) - (1 << 24));
                a2   = pole;
                a1   = -int'($urandom_range(0, (1 << 30) + pole - (1 << 24)));
                gain = $urandom;
            end
            MODE_WILD: begin
                b0   = $urandom;
                a1   = $urandom;
                a2   = $urandom;
                gain = $urandom;
            end
            MODE_EXTREME: begin
                b0   = extreme_coef();
                a1   = extreme_coef();
                a2   = extreme_coef();
                gain = extreme_coef();
            end
            default: begin
                b0   = '0;
                a1   = '0;
                a2   = '0;
                gain = DEF_GAIN;
            end
        endcase
    endfunction

    function automatic logic [31:0] random_pressure();
        logic [15:0] low;
        low = 16'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2:    return {{16{low[15]}}, low};
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input t_coef_val val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        cfg_model[idx] = val;
    endtask

    task automatic release_input();
        if (in_held) begin
            smp_ch.valid <= 1'b0;
            in_held = 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (displacement_q.size() != 0) @(posedge i_clk);
    endtask

    // Valid stays high after a transaction and drops only before a gap, a hold-off,
    // a register write or the end, so it never gets two assignments in one step.
    task automatic send_pressure(input logic [31:0] p, input logic typed,
                                 input t_sample typed_val, input logic hold_off);
        int      gap;
        t_sample pred;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (hold_off) begin
            release_input();
            wait_drained();
        end
        if (gap != 0) begin
            release_input();
            repeat (gap) @(posedge i_clk);
        end
        smp_ch.valid           <= 1'b1;
        smp_ch.pressure_sample <= p;
        in_held = 1'b1;
        @(posedge i_clk);
        while (!smp_ch.ready) @(posedge i_clk);
        pred = predict_displacement(p);
        displacement_q.push_back(typed ? typed_val : pred);
    endtask

    // Result side: random stall before each transaction.
    initial begin
        int stall;
        disp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                disp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            disp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!disp_ch.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && disp_ch.valid && disp_ch.ready) begin
            if (displacement_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected displacement %0d",
                             disp_ch.stapes_displacement);
            end else begin
                want_disp = displacement_q.pop_front();
                if (disp_ch.stapes_displacement !== want_disp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: displacement expected %0d got %0d",
                                 want_disp, disp_ch.stapes_displacement);
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_coef_val  b0, a1, a2, gain;
        t_coef_mode mode;
        int         ph, n;

        smp_ch.valid           <= 1'b0;
        smp_ch.pressure_sample <= '0;
        cfg_wr_en              <= 1'b0;
        cfg_addr               <= CFG_CONCHA_B0;
        cfg_wdata              <= '0;
        i_rst_n                <= 1'b0;

        foreach (cfg_model[k]) cfg_model[k] = '0;
        cfg_model[CFG_CONCHA_GAIN] = DEF_GAIN;
        cfg_model[CFG_CANAL_GAIN]  = DEF_GAIN;
        for (int k = 0; k < 2; k++) begin
            concha_x[k] = '0;  concha_y[k] = '0;
            canal_x[k]  = '0;  canal_y[k]  = '0;
            hp_x[k]     = '0;  hp_y[k]     = '0;
        end
        lp_y = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                release_input();
                wait_drained();
                write_reg(dir_rows[k].reg_idx, dir_rows[k].value);
            end else begin
                send_pressure(dir_rows[k].value, dir_rows[k].typed,
                              dir_rows[k].typed_val, 1'b0);
            end
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            release_input();
            wait_drained();
            mode = (ph == N_PHASES - 1) ? MODE_DEFAULT : t_coef_mode'(ph % 3);
            draw_stage(mode, b0, a1, a2, gain);
            write_reg(CFG_CONCHA_B0, b0);
            write_reg(CFG_CONCHA_A1, a1);
            write_reg(CFG_CONCHA_A2, a2);
            write_reg(CFG_CONCHA_GAIN, gain);
            draw_stage(mode, b0, a1, a2, gain);
            write_reg(CFG_CANAL_B0, b0);
            write_reg(CFG_CANAL_A1, a1);
            write_reg(CFG_CANAL_A2, a2);
            write_reg(CFG_CANAL_GAIN, gain);
            calm = ($urandom_range(0, 3) == 0);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_pressure(random_pressure(), 1'b0, '0,
                              (ph == 0 && n == 60) || ($urandom_range(0, 99) == 0));
        end

        release_input();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
